[hdl/blol_pkg.sv]
`timescale 1ns / 1ps
// Package for the bounded ordered list engine: opcodes, field widths and the
// word types passed between the sequencer and the top level. No dependencies.
package blol_pkg;

  localparam int OPCODE_W = 4;
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = 7;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INS_FRONT = 4'd0,
    OP_INS_BACK  = 4'd1,
    OP_INS_AT    = 4'd2,
    OP_REM_FRONT = 4'd3,
    OP_REM_BACK  = 4'd4,
    OP_REM_AT    = 4'd5,
    OP_SEARCH    = 4'd6,
    OP_READ      = 4'd7,
    OP_REPLACE   = 4'd8
  } blol_op_t;

  typedef struct packed {
    logic [OPCODE_W-1:0]      opcode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] item_value;
  } blol_cmd_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] read_value;
    logic [IDX_W-1:0]         found_at;
    logic [IDX_W-1:0]         count;
    logic                     is_empty;
    logic                     is_full;
  } blol_result_t;

endpackage

[hdl/blol_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the command and result words.
// Depends on blol_pkg for field widths.
interface blol_in_if;
  logic                               valid;
  logic                               ready;
  logic [blol_pkg::OPCODE_W-1:0]      opcode;
  logic [blol_pkg::POS_W-1:0]         position;
  logic signed [blol_pkg::DATA_W-1:0] item_value;

  modport source (output valid, output opcode, output position, output item_value,
                  input ready);
  modport sink   (input valid, input opcode, input position, input item_value,
                  output ready);
endinterface

interface blol_out_if;
  logic                               valid;
  logic                               ready;
  logic                               ok;
  logic signed [blol_pkg::DATA_W-1:0] read_value;
  logic [blol_pkg::IDX_W-1:0]         found_at;
  logic [blol_pkg::IDX_W-1:0]         count;
  logic                               is_empty;
  logic                               is_full;

  modport source (output valid, output ok, output read_value, output found_at,
                  output count, output is_empty, output is_full, input ready);
  modport sink   (input valid, input ok, input read_value, input found_at,
                  input count, input is_empty, input is_full, output ready);
endinterface

[hdl/blol_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module blol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/blol_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer for the ordered list: decodes a command word, moves entries through
// the list RAM one per cycle, scans for values and builds the result word. Uses blol_pkg.
module blol_ctrl #(
  parameter int CAPACITY_MAX = 64,
  parameter int VALUE_WIDTH  = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cmd_valid,
  input  blol_pkg::blol_cmd_t             cmd,
  output logic                            cmd_ready,
  output logic                            res_valid,
  output blol_pkg::blol_result_t          res,
  input  logic                            res_take,
  output logic                            mem_we,
  output logic [$clog2(CAPACITY_MAX)-1:0] mem_waddr,
  output logic [VALUE_WIDTH-1:0]          mem_wdata,
  output logic [$clog2(CAPACITY_MAX)-1:0] mem_raddr,
  input  logic [VALUE_WIDTH-1:0]          mem_rdata
);

  localparam int AW   = $clog2(CAPACITY_MAX);
  localparam int CW   = $clog2(CAPACITY_MAX + 1);
  localparam int CMPW = (CW > blol_pkg::POS_W) ? CW : blol_pkg::POS_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MOVE = 5'b00010,
    S_SCAN = 5'b00100,
    S_READ = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [CW-1:0]                   count_r, count_nxt;
  logic                            pend_r, pend_nxt;
  logic [AW-1:0]                   pend_addr_r, pend_addr_nxt;
  logic [AW-1:0]                   rd_addr_r, rd_addr_nxt;
  logic [CW-1:0]                   rem_r, rem_nxt;
  logic                            up_r, up_nxt;
  logic [AW-1:0]                   ins_addr_r, ins_addr_nxt;
  logic [VALUE_WIDTH-1:0]          val_r, val_nxt;
  logic                            ok_r, ok_nxt;
  logic signed [blol_pkg::DATA_W-1:0] rdv_r, rdv_nxt;
  logic [blol_pkg::IDX_W-1:0]      found_r, found_nxt;

  logic [CMPW-1:0]                 pos_c, cnt_c, idx_c;
  logic                            full;
  logic [VALUE_WIDTH-1:0]          cmd_val;
  logic signed [VALUE_WIDTH-1:0]   rdata_s;
  blol_pkg::blol_op_t              op;

  assign pos_c     = CMPW'(cmd.position);
  assign cnt_c     = CMPW'(count_r);
  assign full      = (count_r == CW'(CAPACITY_MAX));
  assign cmd_val   = VALUE_WIDTH'(cmd.item_value);
  assign rdata_s   = mem_rdata;
  assign op        = blol_pkg::blol_op_t'(cmd.opcode);
  assign cmd_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_FIN);

  always_comb begin
    res.ok         = ok_r;
    res.read_value = rdv_r;
    res.found_at   = found_r;
    res.count      = blol_pkg::IDX_W'(count_r);
    res.is_empty   = (count_r == '0);
    res.is_full    = full;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    rd_addr_nxt   = rd_addr_r;
    rem_nxt       = rem_r;
    up_nxt        = up_r;
    ins_addr_nxt  = ins_addr_r;
    val_nxt       = val_r;
    ok_nxt        = ok_r;
    rdv_nxt       = rdv_r;
    found_nxt     = found_r;
    idx_c         = '0;
    mem_we        = 1'b0;
    mem_waddr     = pend_addr_r;
    mem_wdata     = mem_rdata;
    mem_raddr     = rd_addr_r;

    case (state_r)
      S_IDLE: begin
        if (pos_c < cnt_c) begin
          mem_raddr = AW'(pos_c);
        end else begin
          mem_raddr = AW'(cnt_c - 1'b1);
        end
        if (cmd_valid) begin
          ok_nxt    = 1'b0;
          rdv_nxt   = '0;
          found_nxt = '0;
          val_nxt   = cmd_val;
          pend_nxt  = 1'b0;
          state_nxt = S_FIN;
          case (op)
            blol_pkg::OP_INS_FRONT, blol_pkg::OP_INS_BACK, blol_pkg::OP_INS_AT: begin
              if (op == blol_pkg::OP_INS_FRONT) begin
                idx_c = '0;
              end else if (op == blol_pkg::OP_INS_BACK) begin
                idx_c = cnt_c;
              end else begin
                idx_c = pos_c;
              end
              if (!full && idx_c <= cnt_c) begin
                ok_nxt       = 1'b1;
                up_nxt       = 1'b1;
                ins_addr_nxt = AW'(idx_c);
                rem_nxt      = CW'(cnt_c - idx_c);
                rd_addr_nxt  = AW'(cnt_c - 1'b1);
                state_nxt    = S_MOVE;
              end
            end
            blol_pkg::OP_REM_FRONT, blol_pkg::OP_REM_BACK, blol_pkg::OP_REM_AT: begin
              if (op == blol_pkg::OP_REM_FRONT) begin
                idx_c = '0;
              end else if (op == blol_pkg::OP_REM_BACK) begin
                idx_c = cnt_c - 1'b1;
              end else begin
                idx_c = pos_c;
              end
              if (count_r != '0 && idx_c < cnt_c) begin
                ok_nxt      = 1'b1;
                up_nxt      = 1'b0;
                rem_nxt     = CW'(cnt_c - idx_c - 1'b1);
                rd_addr_nxt = AW'(idx_c + 1'b1);
                state_nxt   = S_MOVE;
              end
            end
            blol_pkg::OP_SEARCH: begin
              rem_nxt     = count_r;
              rd_addr_nxt = '0;
              state_nxt   = S_SCAN;
            end
            blol_pkg::OP_READ: begin
              if (count_r == '0) begin
                rdv_nxt = '1;
              end else begin
                ok_nxt    = (pos_c < cnt_c);
                state_nxt = S_READ;
              end
            end
            blol_pkg::OP_REPLACE: begin
              if (pos_c < cnt_c) begin
                ok_nxt    = 1'b1;
                mem_we    = 1'b1;
                mem_waddr = AW'(pos_c);
                mem_wdata = cmd_val;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_MOVE: begin
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr_r;
          mem_wdata = mem_rdata;
        end
        if (rem_r != '0) begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = up_r ? AW'(rd_addr_r + 1'b1) : AW'(rd_addr_r - 1'b1);
          rd_addr_nxt   = up_r ? AW'(rd_addr_r - 1'b1) : AW'(rd_addr_r + 1'b1);
          rem_nxt       = CW'(rem_r - 1'b1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            if (up_r) begin
              mem_we    = 1'b1;
              mem_waddr = ins_addr_r;
              mem_wdata = val_r;
              count_nxt = CW'(count_r + 1'b1);
            end else begin
              count_nxt = CW'(count_r - 1'b1);
            end
            state_nxt = S_FIN;
          end
        end
      end

      S_SCAN: begin
        if (pend_r && mem_rdata == val_r) begin
          ok_nxt    = 1'b1;
          found_nxt = blol_pkg::IDX_W'(pend_addr_r);
          pend_nxt  = 1'b0;
          state_nxt = S_FIN;
        end else if (rem_r != '0) begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = rd_addr_r;
          rd_addr_nxt   = AW'(rd_addr_r + 1'b1);
          rem_nxt       = CW'(rem_r - 1'b1);
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          found_nxt = blol_pkg::IDX_W'(count_r);
          state_nxt = S_FIN;
        end
      end

      S_READ: begin
        rdv_nxt   = blol_pkg::DATA_W'(rdata_s);
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    rd_addr_r   <= rd_addr_nxt;
    rem_r       <= rem_nxt;
    up_r        <= up_nxt;
    ins_addr_r  <= ins_addr_nxt;
    val_r       <= val_nxt;
    ok_r        <= ok_nxt;
    rdv_r       <= rdv_nxt;
    found_r     <= found_nxt;
  end

endmodule

[hdl/bounded_ordered_list_engine_top.sv]
`timescale 1ns / 1ps
// Bounded ordered list engine: keeps up to CAPACITY_MAX signed values in order in one
// list RAM with a count, taking one command word at a time and returning one result word
// for each. Inserts and removes shift the entries behind the index one per cycle through
// the RAM's single read and write port: an insert moves count - index entries and a
// remove moves count - index - 1. A search reads one entry per cycle until it finds the
// value or reaches the end of the list. The result word is in the output register in the
// same cycle that the next command can be taken, and a stalled result holds the engine.
// No clearing pass after reset. Depends on blol_pkg, blol_if, blol_ram and blol_ctrl.
module bounded_ordered_list_engine_top #(
  parameter int CAPACITY_MAX = 64,
  parameter int VALUE_WIDTH  = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  blol_in_if.sink    in_ch,
  blol_out_if.source out_ch
);

  localparam int AW = $clog2(CAPACITY_MAX);

  blol_pkg::blol_cmd_t    cmd;
  blol_pkg::blol_result_t res;
  blol_pkg::blol_result_t out_word_r;
  logic                   out_valid_r;
  logic                   res_valid;
  logic                   res_take;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [AW-1:0]          mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic [VALUE_WIDTH-1:0] mem_rdata;

  assign cmd.opcode     = in_ch.opcode;
  assign cmd.position   = in_ch.position;
  assign cmd.item_value = in_ch.item_value;
  assign res_take       = !out_valid_r || out_ch.ready;

  blol_ctrl #(
    .CAPACITY_MAX (CAPACITY_MAX),
    .VALUE_WIDTH  (VALUE_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_ch.valid),
    .cmd       (cmd),
    .cmd_ready (in_ch.ready),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  blol_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (CAPACITY_MAX)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_word_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.ok         = out_word_r.ok;
  assign out_ch.read_value = out_word_r.read_value;
  assign out_ch.found_at   = out_word_r.found_at;
  assign out_ch.count      = out_word_r.count;
  assign out_ch.is_empty   = out_word_r.is_empty;
  assign out_ch.is_full    = out_word_r.is_full;

endmodule
